// File: rtl/core/mlst_pkg.sv
// Shared types and constants for the max line segment tree unit.
package mlst_pkg;

    localparam int unsigned SLOPE_W = 32;
    localparam int unsigned ICPT_W  = 32;
    localparam int unsigned POINT_W = 17;
    localparam int unsigned VALUE_W = 48;
    localparam int unsigned LINE_W  = SLOPE_W + ICPT_W;

    // intercept of the empty line every node holds after reset
    localparam logic signed [ICPT_W-1:0] EMPTY_ICPT = -32'sh3f3f3f3f;

    // multiplier x operand select
    localparam logic [1:0] SEL_PT  = 2'd0;
    localparam logic [1:0] SEL_MID = 2'd1;
    localparam logic [1:0] SEL_LO  = 2'd2;
    localparam logic [1:0] SEL_HI  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       clr_step;
        logic       rd;
        logic       latch;
        logic [1:0] mul_sel;
        logic       cap_mid;
        logic       cap_lo;
        logic       dec;
        logic       q_step;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic at_leaf;
        logic ins_more;
    } t_sts;

endpackage

// File: rtl/core/mlst_if.sv
// Valid/ready channel interfaces for the input and result words.
interface mlst_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   mode;
    logic signed [mlst_pkg::SLOPE_W-1:0]    line_slope;
    logic signed [mlst_pkg::ICPT_W-1:0]     line_intercept;
    logic        [mlst_pkg::POINT_W-1:0]    point;

    modport source (output valid, mode, line_slope, line_intercept, point, input ready);
    modport sink   (input valid, mode, line_slope, line_intercept, point, output ready);
endinterface

interface mlst_out_if;
    logic                           valid;
    logic                           ready;
    logic [mlst_pkg::VALUE_W-1:0]   best_value;

    modport source (output valid, best_value, input ready);
    modport sink   (input valid, best_value, output ready);
endinterface

// File: rtl/core/mlst_ram.sv
// Generic simple dual-port RAM with registered read.
module mlst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/mlst_ctrl.sv
// Controller state machine: sequences clear pass, tree walk and result hand-off.
module mlst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mlst_pkg::t_cmd o_cmd,
    input  mlst_pkg::t_sts i_sts
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD    = 4'd2;
    localparam logic [3:0] S_DAT   = 4'd3;
    localparam logic [3:0] S_MUL0  = 4'd4;
    localparam logic [3:0] S_MUL1  = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_DEC   = 4'd7;
    localparam logic [3:0] S_QADD  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DAT;
            end
            S_DAT: begin
                o_cmd.latch = 1'b1;
                n_state     = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul_sel = i_sts.is_query ? mlst_pkg::SEL_PT : mlst_pkg::SEL_MID;
                n_state       = i_sts.is_query ? S_QADD : S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_sel = mlst_pkg::SEL_LO;
                o_cmd.cap_mid = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_sel = mlst_pkg::SEL_HI;
                o_cmd.cap_lo  = 1'b1;
                n_state       = S_DEC;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = i_sts.ins_more ? S_RD : S_IDLE;
            end
            S_QADD: begin
                o_cmd.q_step = 1'b1;
                n_state      = i_sts.at_leaf ? S_OUT : S_RD;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/mlst_dpath.sv
// Datapath: node memory, shared line evaluator, walk registers and result register.
module mlst_dpath #(
    parameter int X_MAX = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mlst_pkg::t_cmd                       i_cmd,
    output mlst_pkg::t_sts                       o_sts,
    input  logic                                 i_mode,
    input  logic signed [mlst_pkg::SLOPE_W-1:0]  i_line_slope,
    input  logic signed [mlst_pkg::ICPT_W-1:0]   i_line_intercept,
    input  logic        [mlst_pkg::POINT_W-1:0]  i_point,
    output logic        [mlst_pkg::VALUE_W-1:0]  o_best_value
);

    localparam int XW    = $clog2(X_MAX + 1);
    localparam int IW    = $clog2(X_MAX) + 1;
    localparam int DEPTH = 1 << IW;
    localparam int PW    = mlst_pkg::POINT_W;
    localparam int MW    = (XW > PW) ? XW : PW;
    localparam int AW    = mlst_pkg::SLOPE_W + 1;
    localparam int PRW   = AW + MW + 1;
    localparam int SW    = PRW + 1;
    localparam int VW    = mlst_pkg::VALUE_W;

    logic                               r_is_query;
    logic        [PW-1:0]               r_point;
    logic signed [mlst_pkg::SLOPE_W-1:0] r_cs, r_ns;
    logic signed [mlst_pkg::ICPT_W-1:0]  r_ci, r_ni;
    logic signed [AW-1:0]               r_a, r_b;
    logic        [IW-1:0]               r_idx;
    logic        [XW-1:0]               r_lo, r_hi;
    logic signed [PRW-1:0]              r_prod;
    logic                               r_gt_mid, r_gt_lo, r_lt_lo;
    logic signed [SW-1:0]               r_best;
    logic        [IW-1:0]               r_clr;
    logic        [VW-1:0]               r_value;

    logic        [XW:0]                 w_lh_sum;
    logic        [XW-1:0]               w_mid;
    logic        [MW-1:0]               w_x;
    logic signed [PRW-1:0]              w_prod;
    logic signed [SW-1:0]               w_sum;
    logic                               w_gt, w_lt;
    logic                               w_swap, w_left, w_right, w_q_left, w_at_leaf;
    logic signed [mlst_pkg::SLOPE_W-1:0] w_rd_s;
    logic signed [mlst_pkg::ICPT_W-1:0]  w_rd_i;

    logic                               w_wr_en;
    logic [IW-1:0]                      w_wr_addr;
    logic [mlst_pkg::LINE_W-1:0]        w_wr_data, w_rd_data;

    assign w_lh_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_lh_sum[XW:1];
    assign w_at_leaf = (r_lo == r_hi);

    always_comb begin
        case (i_cmd.mul_sel)
            mlst_pkg::SEL_MID: w_x = MW'(w_mid);
            mlst_pkg::SEL_LO:  w_x = MW'(r_lo);
            mlst_pkg::SEL_HI:  w_x = MW'(r_hi);
            default:           w_x = MW'(r_point);
        endcase
    end

    // a is a line difference on insert, the node line on query
    assign w_prod = r_a * $signed({1'b0, w_x});
    assign w_sum  = SW'(r_prod) + SW'(r_b);
    assign w_lt   = w_sum[SW-1];
    assign w_gt   = !w_sum[SW-1] && (w_sum != '0);

    // carried line wins at mid -> it stays; loser goes where it is still higher
    assign w_swap   = r_gt_mid;
    assign w_left   = w_swap ? r_lt_lo : r_gt_lo;
    assign w_right  = w_swap ? w_lt : w_gt;
    assign w_q_left = (MW'(r_point) <= MW'(w_mid));

    assign w_rd_s = w_rd_data[mlst_pkg::LINE_W-1:mlst_pkg::ICPT_W];
    assign w_rd_i = w_rd_data[mlst_pkg::ICPT_W-1:0];

    assign w_wr_en   = i_cmd.clr_step || (i_cmd.dec && w_swap);
    assign w_wr_addr = i_cmd.clr_step ? r_clr : r_idx;
    assign w_wr_data = i_cmd.clr_step ? {{mlst_pkg::SLOPE_W{1'b0}}, mlst_pkg::EMPTY_ICPT}
                                      : {r_cs, r_ci};

    mlst_ram #(
        .WIDTH (mlst_pkg::LINE_W),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_cmd.load) begin
            r_is_query <= i_mode;
            r_point    <= i_point;
            r_cs       <= i_line_slope;
            r_ci       <= i_line_intercept;
            r_idx      <= IW'(1);
            r_lo       <= XW'(1);
            r_hi       <= XW'(X_MAX);
            r_best     <= '0;
        end
        if (i_cmd.latch) begin
            r_ns <= w_rd_s;
            r_ni <= w_rd_i;
            if (r_is_query) begin
                r_a <= AW'(w_rd_s);
                r_b <= AW'(w_rd_i);
            end else begin
                r_a <= AW'(r_cs) - AW'(w_rd_s);
                r_b <= AW'(r_ci) - AW'(w_rd_i);
            end
        end
        if (i_cmd.cap_mid) begin
            r_gt_mid <= w_gt;
        end
        if (i_cmd.cap_lo) begin
            r_gt_lo <= w_gt;
            r_lt_lo <= w_lt;
        end
        if (i_cmd.dec) begin
            if (w_swap) begin
                r_cs <= r_ns;
                r_ci <= r_ni;
            end
            if (w_left) begin
                r_idx <= {r_idx[IW-2:0], 1'b0};
                r_hi  <= w_mid;
            end else if (w_right) begin
                r_idx <= {r_idx[IW-2:0], 1'b1};
                r_lo  <= w_mid + XW'(1);
            end
        end
        if (i_cmd.q_step) begin
            if (w_sum > r_best) begin
                r_best <= w_sum;
            end
            if (!w_at_leaf) begin
                if (w_q_left) begin
                    r_idx <= {r_idx[IW-2:0], 1'b0};
                    r_hi  <= w_mid;
                end else begin
                    r_idx <= {r_idx[IW-2:0], 1'b1};
                    r_lo  <= w_mid + XW'(1);
                end
            end
        end
        if (i_cmd.out_load) begin
            // best is never negative; saturate at the field width
            r_value <= (|r_best[SW-1:VW]) ? {VW{1'b1}} : r_best[VW-1:0];
        end
    end

    assign o_sts.clr_last = &r_clr;
    assign o_sts.is_query = r_is_query;
    assign o_sts.at_leaf  = w_at_leaf;
    assign o_sts.ins_more = w_left || w_right;
    assign o_best_value   = r_value;

endmodule

// File: rtl/core/max_line_segment_tree_unit.sv
// Top level of the max line segment tree unit: Li Chao tree, upper envelope of lines.
//
//  channel  | dir | handshake       | word
//  i_in     | in  | valid / ready   | mode, line_slope, line_intercept, point
//  o_out    | out | valid / ready   | best_value (queries only)
//
// One word is in the tree walk at a time; L = clog2(X_MAX) + 1 levels (17 by default).
// Insert: per level walked, memory read, read data, three products on one shared
// multiplier, and decide/write. Query: walks from root to leaf, plus any wait for
// the result register to drain. After reset a clearing pass writes every node, one
// per cycle; no word is accepted until it ends. The result register lets the next
// word enter while a result waits for o_out.ready.
module max_line_segment_tree_unit #(
    parameter int X_MAX = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mlst_in_if.sink           i_in,
    mlst_out_if.source        o_out
);

    mlst_pkg::t_cmd w_cmd;
    mlst_pkg::t_sts w_sts;

    mlst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    mlst_dpath #(
        .X_MAX (X_MAX)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_mode           (i_in.mode),
        .i_line_slope     (i_in.line_slope),
        .i_line_intercept (i_in.line_intercept),
        .i_point          (i_in.point),
        .o_best_value     (o_out.best_value)
    );

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_step |-> !i_in.ready)
        else $error("word accepted during clearing pass");

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.clr_step, w_cmd.rd, w_cmd.dec, w_cmd.q_step, w_cmd.load}))
        else $error("conflicting datapath commands");

    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.out_load))
        else $error("result valid without a finished query");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out.valid || o_out.ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule
